[src/set_assoc_cache_tree_plru_unit_macros.svh]
// Assertion macros shared by the cache unit.
`ifndef SET_ASSOC_CACHE_TREE_PLRU_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_TREE_PLRU_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SACP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sacp: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SACP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sacp: next-cycle check failed");

`endif

[src/sacp_pkg.sv]
// Types, constants and PLRU helpers for the set-associative cache unit.
package sacp_pkg;

   localparam int DEF_NUM_SETS   = 1024;
   localparam int DEF_VALUE_BITS = 32;
   localparam int WAYS           = 4;
   localparam int WAY_BITS       = 2;
   localparam int KEY_W          = 64;
   localparam int VALUE_W        = 32;
   localparam int COUNT_W        = 64;
   localparam int PLRU_W         = 3;
   localparam logic [KEY_W-1:0] MIX_MULT = 64'h9E37_79B9_7F4A_7C15;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_CLEAR  = 2'd2
   } sacp_kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_X1,
      ST_MUL_X2,
      ST_REDUCE,
      ST_READ,
      ST_UPDATE,
      ST_RESPOND
   } sacp_state_type;

   // Per-set bookkeeping row: valid bit per way and the tree bits.
   typedef struct packed {
      logic [WAYS-1:0]   valid;
      logic [PLRU_W-1:0] plru;
   } sacp_meta_type;

   // Bit 0 picks the half, bit 1 the left pair, bit 2 the right pair.
   function automatic logic [WAY_BITS-1:0] plru_victim(input logic [PLRU_W-1:0] t);
      logic [WAY_BITS-1:0] w;
      if (!t[0]) begin
         w = t[1] ? 2'd1 : 2'd0;
      end else begin
         w = t[2] ? 2'd3 : 2'd2;
      end
      return w;
   endfunction

   // Point the tree away from the way just used.
   function automatic logic [PLRU_W-1:0] plru_touch(input logic [PLRU_W-1:0] t,
                                                     input logic [WAY_BITS-1:0] way);
      logic [PLRU_W-1:0] r;
      r = t;
      case (way)
         2'd0: begin
            r[0] = 1'b1;
            r[1] = 1'b1;
         end
         2'd1: begin
            r[0] = 1'b1;
            r[1] = 1'b0;
         end
         2'd2: begin
            r[0] = 1'b0;
            r[2] = 1'b1;
         end
         default: begin
            r[0] = 1'b0;
            r[2] = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

[src/sacp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sacp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // Hold read data until the next read.
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/set_assoc_cache_tree_plru_unit.sv]
// Top level of the four-way set-associative key/value cache with tree PLRU.
// Four-way set-associative key/value cache. A lookup (kind 0) reports hit, way and stored
// value and touches the way; an insert (kind 1) updates a matching way, else fills the lowest
// invalid way, else replaces the tree-PLRU victim; a clear (kind 2) empties the cache and
// zeroes the hit, miss and eviction counters; kind 3 does nothing but report the totals.
// Every item returns exactly one result carrying the counters as they stand after it.
// The set index is the 64-bit multiplicative hash of the key, folded high half into low,
// reduced modulo NUM_SETS. The hash runs through one shared 32x32 multiplier in three
// passes, so a lookup or insert steps through the accepting idle state, the three
// multiplier passes, the index, the set read and the update; no new item is taken until
// the unit is back in idle. Its result becomes valid when the update hands it to the
// output register, and req_ready is high again in the same cycle. A set count that is not
// a power of two turns the index into an eight-bit-per-cycle modulo reduction.
// A set lives in two RAMs with registered reads: a row of valid bits and tree bits, and a
// row of four tags and payloads; the update cycle reads the returned rows, modifies them
// and writes them back. A clear sweeps the valid/tree RAM one set per cycle and then
// returns its result. After reset the same sweep runs with req_ready low. The result sits
// in an output register, so the next item is taken while a result waits; the update of
// that next item holds until the waiting result has been taken.
`include "set_assoc_cache_tree_plru_unit_macros.svh"

module set_assoc_cache_tree_plru_unit
   import sacp_pkg::*;
#(
   parameter int NUM_SETS   = DEF_NUM_SETS,
   parameter int VALUE_BITS = DEF_VALUE_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_value_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [VALUE_W-1:0] rsp_value_out,
   output logic [WAY_BITS-1:0] rsp_way_used,
   output logic               rsp_evicted,
   output logic [COUNT_W-1:0] rsp_hit_count,
   output logic [COUNT_W-1:0] rsp_miss_count,
   output logic [COUNT_W-1:0] rsp_eviction_count
);

   localparam int SET_BITS  = $clog2(NUM_SETS);
   localparam int WAY_W     = KEY_W + VALUE_BITS;
   localparam int META_W    = $bits(sacp_meta_type);
   localparam bit SETS_POW2 = (NUM_SETS & (NUM_SETS - 1)) == 0;
   localparam logic [SET_BITS:0]   SETS_WIDE = (SET_BITS + 1)'(NUM_SETS);
   localparam logic [SET_BITS-1:0] LAST_SET  = SET_BITS'(NUM_SETS - 1);

   // Control registers.
   sacp_state_type state_ff, state_in;
   logic [SET_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic                clr_resp_ff, clr_resp_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  hits_ff, hits_in;
   logic [COUNT_W-1:0]  misses_ff, misses_in;
   logic [COUNT_W-1:0]  evictions_ff, evictions_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Item and result payload registers.
   logic [1:0]            kind_ff, kind_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [KEY_W-1:0]      acc_ff, acc_in;
   logic [SET_BITS-1:0]   set_ff, set_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [WAY_BITS-1:0]   rsp_way_ff, rsp_way_in;
   logic                  rsp_evicted_ff, rsp_evicted_in;
   logic [COUNT_W-1:0]    rsp_hits_ff, rsp_hits_in;
   logic [COUNT_W-1:0]    rsp_misses_ff, rsp_misses_in;
   logic [COUNT_W-1:0]    rsp_evictions_ff, rsp_evictions_in;

   // Datapath.
   logic [31:0]          mul_a, mul_b;
   logic [KEY_W-1:0]     prod;
   logic [KEY_W-1:0]     mix;
   logic [7:0]           digit;
   logic [SET_BITS:0]    rem_work;
   logic [SET_BITS-1:0]  rem_next;
   logic                 out_free;

   // RAM ports.
   logic                          meta_wr_en;
   logic [SET_BITS-1:0]           meta_wr_addr;
   sacp_meta_type                 meta_wr_data;
   sacp_meta_type                 meta_rd;
   logic                          data_wr_en;
   logic [WAYS-1:0][WAY_W-1:0]    data_wr_data;
   logic [WAYS-1:0][WAY_W-1:0]    data_rd;
   logic                          rd_en;

   // Set lookup results.
   logic [WAYS-1:0]     way_match;
   logic                found;
   logic [WAY_BITS-1:0] hit_way;
   logic                any_free;
   logic [WAY_BITS-1:0] free_way;
   logic [WAY_BITS-1:0] ins_way;
   logic                ins_evict;

   // Assertion helpers.
   logic                lookup_done;
   logic [COUNT_W-1:0]  looked_total;

   sacp_ram #(
      .WIDTH(META_W),
      .DEPTH(NUM_SETS)
   ) u_meta_ram (
      .clock  (clock),
      .wr_en  (meta_wr_en),
      .wr_addr(meta_wr_addr),
      .wr_data(meta_wr_data),
      .rd_en  (rd_en),
      .rd_addr(set_ff),
      .rd_data(meta_rd)
   );

   sacp_ram #(
      .WIDTH(WAYS * WAY_W),
      .DEPTH(NUM_SETS)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (data_wr_en),
      .wr_addr(set_ff),
      .wr_data(data_wr_data),
      .rd_en  (rd_en),
      .rd_addr(set_ff),
      .rd_data(data_rd)
   );

   // One shared 32x32 multiplier for the three partial products of the hash.
   assign prod = KEY_W'(mul_a) * KEY_W'(mul_b);

   // Fold the high half of the hash into the low half.
   assign mix = {acc_ff[KEY_W-1:32], acc_ff[KEY_W-1:32] ^ acc_ff[31:0]};

   // Modulo reduction: fold in eight bits of the mixed value per cycle, MSB first.
   assign digit = 8'(mix >> {3'd7 - cnt_ff, 3'b000});

   always_comb begin
      rem_work = {1'b0, set_ff};
      for (int i = 0; i < 8; i++) begin
         rem_work = {rem_work[SET_BITS-1:0], digit[7-i]};
         if (rem_work >= SETS_WIDE) begin
            rem_work = rem_work - SETS_WIDE;
         end
      end
      rem_next = rem_work[SET_BITS-1:0];
   end

   // Compare tags of the returned set and pick ways.
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_match[w] = meta_rd.valid[w] && (data_rd[w][WAY_W-1 -: KEY_W] == key_ff);
      end
      found    = |way_match;
      any_free = ~&meta_rd.valid;
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (way_match[w]) begin
            hit_way = WAY_BITS'(w);
         end
         if (!meta_rd.valid[w]) begin
            free_way = WAY_BITS'(w);
         end
      end
      ins_evict = !found && !any_free;
      if (found) begin
         ins_way = hit_way;
      end else if (any_free) begin
         ins_way = free_way;
      end else begin
         ins_way = plru_victim(meta_rd.plru);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state, datapath and RAM controls.
   always_comb begin
      state_in         = state_ff;
      clr_idx_in       = clr_idx_ff;
      clr_resp_in      = clr_resp_ff;
      cnt_in           = cnt_ff;
      hits_in          = hits_ff;
      misses_in        = misses_ff;
      evictions_in     = evictions_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      kind_in          = kind_ff;
      key_in           = key_ff;
      val_in           = val_ff;
      acc_in           = acc_ff;
      set_in           = set_ff;
      rsp_hit_in       = rsp_hit_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_way_in       = rsp_way_ff;
      rsp_evicted_in   = rsp_evicted_ff;
      rsp_hits_in      = rsp_hits_ff;
      rsp_misses_in    = rsp_misses_ff;
      rsp_evictions_in = rsp_evictions_ff;
      mul_a            = key_ff[31:0];
      mul_b            = MIX_MULT[31:0];
      meta_wr_en       = 1'b0;
      meta_wr_addr     = set_ff;
      meta_wr_data     = meta_rd;
      data_wr_en       = 1'b0;
      data_wr_data     = data_rd;
      rd_en            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               key_in  = req_key;
               val_in  = VALUE_BITS'(req_value_in);
               case (req_kind)
                  KIND_LOOKUP, KIND_INSERT: begin
                     state_in = ST_MUL_LO;
                  end
                  KIND_CLEAR: begin
                     // Zero the counters now; sweep the sets, then answer.
                     hits_in      = '0;
                     misses_in    = '0;
                     evictions_in = '0;
                     clr_idx_in   = '0;
                     clr_resp_in  = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_RESPOND;
                  end
               endcase
            end
         end
         ST_MUL_LO: begin
            acc_in   = prod;
            state_in = ST_MUL_X1;
         end
         ST_MUL_X1: begin
            mul_b             = MIX_MULT[KEY_W-1:32];
            acc_in[KEY_W-1:32] = acc_ff[KEY_W-1:32] + prod[31:0];
            state_in          = ST_MUL_X2;
         end
         ST_MUL_X2: begin
            mul_a             = key_ff[KEY_W-1:32];
            acc_in[KEY_W-1:32] = acc_ff[KEY_W-1:32] + prod[31:0];
            set_in            = '0;
            cnt_in            = '0;
            state_in          = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (SETS_POW2) begin
               set_in   = mix[SET_BITS-1:0];
               state_in = ST_READ;
            end else begin
               set_in = rem_next;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Hold until the previous result is taken; read data stays put meanwhile.
            if (out_free) begin
               rsp_hit_in     = 1'b0;
               rsp_value_in   = '0;
               rsp_way_in     = '0;
               rsp_evicted_in = 1'b0;
               if (kind_ff == KIND_LOOKUP) begin
                  if (found) begin
                     rsp_hit_in        = 1'b1;
                     rsp_value_in      = VALUE_W'(data_rd[hit_way][VALUE_BITS-1:0]);
                     rsp_way_in        = hit_way;
                     meta_wr_en        = 1'b1;
                     meta_wr_data.plru = plru_touch(meta_rd.plru, hit_way);
                     hits_in           = hits_ff + COUNT_W'(1);
                  end else begin
                     misses_in = misses_ff + COUNT_W'(1);
                  end
               end else begin
                  rsp_hit_in     = found;
                  rsp_way_in     = ins_way;
                  rsp_evicted_in = ins_evict;
                  if (ins_evict) begin
                     evictions_in = evictions_ff + COUNT_W'(1);
                  end
                  data_wr_en                  = 1'b1;
                  data_wr_data[ins_way]       = {key_ff, val_ff};
                  meta_wr_en                  = 1'b1;
                  meta_wr_data.valid[ins_way] = 1'b1;
                  meta_wr_data.plru           = plru_touch(meta_rd.plru, ins_way);
               end
               rsp_hits_in      = hits_in;
               rsp_misses_in    = misses_in;
               rsp_evictions_in = evictions_in;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = clr_idx_ff;
            meta_wr_data = '0;
            clr_idx_in   = clr_idx_ff + SET_BITS'(1);
            if (clr_idx_ff == LAST_SET) begin
               state_in = clr_resp_ff ? ST_RESPOND : ST_IDLE;
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               rsp_hit_in       = 1'b0;
               rsp_value_in     = '0;
               rsp_way_in       = '0;
               rsp_evicted_in   = 1'b0;
               rsp_hits_in      = hits_ff;
               rsp_misses_in    = misses_ff;
               rsp_evictions_in = evictions_ff;
               rsp_valid_in     = 1'b1;
               clr_resp_in      = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         cnt_ff       <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evictions_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_resp_ff  <= clr_resp_in;
         cnt_ff       <= cnt_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evictions_ff <= evictions_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff          <= kind_in;
      key_ff           <= key_in;
      val_ff           <= val_in;
      acc_ff           <= acc_in;
      set_ff           <= set_in;
      rsp_hit_ff       <= rsp_hit_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_way_ff       <= rsp_way_in;
      rsp_evicted_ff   <= rsp_evicted_in;
      rsp_hits_ff      <= rsp_hits_in;
      rsp_misses_ff    <= rsp_misses_in;
      rsp_evictions_ff <= rsp_evictions_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_value_out      = rsp_value_ff;
   assign rsp_way_used       = rsp_way_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_hit_count      = rsp_hits_ff;
   assign rsp_miss_count     = rsp_misses_ff;
   assign rsp_eviction_count = rsp_evictions_ff;

   assign lookup_done  = state_ff == ST_UPDATE && out_free && kind_ff == KIND_LOOKUP;
   assign looked_total = hits_ff + misses_ff;

   // A key lives in at most one way of its set.
   `SACP_ASSERT_SAME(a_single_match, state_ff == ST_UPDATE, $onehot0(way_match))
   // Every completed lookup counts exactly one hit or one miss.
   `SACP_ASSERT_NEXT(a_lookup_counted, lookup_done, looked_total == $past(looked_total) + 64'd1)
   // The sweep only runs with all counters at zero.
   `SACP_ASSERT_SAME(a_clear_zeroed, state_ff == ST_CLEAR, (hits_ff | misses_ff | evictions_ff) == '0)

endmodule

[verif/set_assoc_cache_tree_plru_unit_checker.sv]
// Result checker for the set-associative cache unit: predicts every item and compares.
`timescale 1ns / 1ps

module set_assoc_cache_tree_plru_unit_checker
   import sacp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [VALUE_W-1:0]  req_value_in,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_hit,
   input  logic [VALUE_W-1:0]  rsp_value_out,
   input  logic [WAY_BITS-1:0] rsp_way_used,
   input  logic                rsp_evicted,
   input  logic [COUNT_W-1:0]  rsp_hit_count,
   input  logic [COUNT_W-1:0]  rsp_miss_count,
   input  logic [COUNT_W-1:0]  rsp_eviction_count,
   output int                  mismatch_count,
   output int                  pending_count
);

   localparam int SET_COUNT    = DEF_NUM_SETS;
   localparam int SET_BITS     = $clog2(SET_COUNT);
   localparam int LINE_COUNT   = SET_COUNT * WAYS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                hit;
      logic [VALUE_W-1:0]  value_out;
      logic [WAY_BITS-1:0] way_used;
      logic                evicted;
      logic [COUNT_W-1:0]  hit_count;
      logic [COUNT_W-1:0]  miss_count;
      logic [COUNT_W-1:0]  eviction_count;
   } cache_result_type;

   logic                line_valid   [LINE_COUNT];
   logic [KEY_W-1:0]    line_tag     [LINE_COUNT];
   logic [VALUE_W-1:0]  line_payload [LINE_COUNT];
   logic [PLRU_W-1:0]   set_tree     [SET_COUNT];
   logic [COUNT_W-1:0]  lookup_hits;
   logic [COUNT_W-1:0]  lookup_misses;
   logic [COUNT_W-1:0]  victim_evictions;
   cache_result_type    predicted_results [$];

   function automatic logic [SET_BITS-1:0] set_index(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] mixed;
      mixed = key * MIX_MULT;
      mixed = (mixed >> 32) ^ mixed;
      return SET_BITS'(mixed % SET_COUNT);
   endfunction

   function automatic logic [WAY_BITS-1:0] victim_way(input logic [PLRU_W-1:0] tree);
      if (tree[0]) begin
         return tree[2] ? 2'd3 : 2'd2;
      end
      return tree[1] ? 2'd1 : 2'd0;
   endfunction

   // Root points at the other half, the pair bit at the other way of the pair.
   function automatic logic [PLRU_W-1:0] touched_tree(input logic [PLRU_W-1:0] tree,
                                                      input logic [WAY_BITS-1:0] way);
      logic [PLRU_W-1:0] next;
      next    = tree;
      next[0] = ~way[1];
      if (way[1]) begin
         next[2] = ~way[0];
      end else begin
         next[1] = ~way[0];
      end
      return next;
   endfunction

   task automatic empty_cache();
      int i;
      for (i = 0; i < LINE_COUNT; i++) begin
         line_valid[i] = 1'b0;
      end
      for (i = 0; i < SET_COUNT; i++) begin
         set_tree[i] = '0;
      end
      lookup_hits      = '0;
      lookup_misses    = '0;
      victim_evictions = '0;
   endtask

   task automatic apply_cache_op(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                                 input logic [VALUE_W-1:0] value,
                                 output cache_result_type res);
      int               base;
      int               way;
      int               w;
      bit               found;
      logic [SET_BITS-1:0] set;
      res = '0;
      if (kind == KIND_LOOKUP || kind == KIND_INSERT) begin
         set   = set_index(key);
         base  = int'(set) * WAYS;
         found = 1'b0;
         way   = 0;
         for (w = WAYS - 1; w >= 0; w--) begin
            if (line_valid[base + w] && line_tag[base + w] == key) begin
               found = 1'b1;
               way   = w;
            end
         end
         if (kind == KIND_LOOKUP) begin
            if (found) begin
               res.hit       = 1'b1;
               res.value_out = line_payload[base + way];
               res.way_used  = WAY_BITS'(way);
               set_tree[set] = touched_tree(set_tree[set], WAY_BITS'(way));
               lookup_hits   = lookup_hits + COUNT_W'(1);
            end else begin
               lookup_misses = lookup_misses + COUNT_W'(1);
            end
         end else begin
            if (!found) begin
               way = -1;
               for (w = WAYS - 1; w >= 0; w--) begin
                  if (!line_valid[base + w]) begin
                     way = w;
                  end
               end
               if (way < 0) begin
                  way              = int'(victim_way(set_tree[set]));
                  res.evicted      = 1'b1;
                  victim_evictions = victim_evictions + COUNT_W'(1);
               end
               line_tag[base + way]   = key;
               line_valid[base + way] = 1'b1;
            end
            line_payload[base + way] = value;
            res.hit                  = found;
            res.way_used             = WAY_BITS'(way);
            set_tree[set]            = touched_tree(set_tree[set], WAY_BITS'(way));
         end
      end else if (kind == KIND_CLEAR) begin
         empty_cache();
      end
      res.hit_count      = lookup_hits;
      res.miss_count     = lookup_misses;
      res.eviction_count = victim_evictions;
   endtask

   always @(posedge clock) begin : watch_channels
      cache_result_type want;
      cache_result_type seen;
      if (reset) begin
         empty_cache();
         predicted_results.delete();
         mismatch_count = 0;
      end else begin
         // Take the result first: it can never belong to an item accepted at this edge.
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_hit, rsp_value_out, rsp_way_used, rsp_evicted,
                     rsp_hit_count, rsp_miss_count, rsp_eviction_count};
            if (predicted_results.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("%0t: result with nothing expected", $realtime);
               end
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               if (seen.hit !== want.hit || seen.value_out !== want.value_out ||
                   seen.way_used !== want.way_used || seen.evicted !== want.evicted ||
                   seen.hit_count !== want.hit_count || seen.miss_count !== want.miss_count ||
                   seen.eviction_count !== want.eviction_count) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("%0t: expected hit %0d value %h way %0d evicted %0d counts %0d %0d %0d",
                              $realtime, want.hit, want.value_out, want.way_used, want.evicted,
                              want.hit_count, want.miss_count, want.eviction_count);
                     $display("%0t: actual   hit %0d value %h way %0d evicted %0d counts %0d %0d %0d",
                              $realtime, seen.hit, seen.value_out, seen.way_used, seen.evicted,
                              seen.hit_count, seen.miss_count, seen.eviction_count);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_cache_op(req_kind, req_key, req_value_in, want);
            predicted_results.push_back(want);
         end
      end
      pending_count = predicted_results.size();
   end

endmodule

[verif/set_assoc_cache_tree_plru_unit_test.sv]
// Testbench top for the set-associative cache unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module set_assoc_cache_tree_plru_unit_test
   import sacp_pkg::*;
();

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 500;
   // Longest quiet stretch of a correct run is a clear sweep or the long
   // receiver hold-off; allow several times that.
   localparam int IDLE_LIMIT   = 6000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_AT      = 150;
   localparam int PAUSE_AT     = 320;
   // The set index depends only on the key bits below this one, since the hash
   // keeps product bits 41:32 and 9:0. Keys that differ above it share a set.
   localparam int SET_KEY_BITS = 42;
   localparam int TOP_KEY_BITS = KEY_W - SET_KEY_BITS;
   localparam int TOP_POOL     = 8;
   localparam int BASE_POOL    = 6;
   localparam logic [1:0] KIND_NOP = 2'd3;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [1:0]          req_kind     = KIND_LOOKUP;
   logic [KEY_W-1:0]    req_key      = '0;
   logic [VALUE_W-1:0]  req_value_in = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic                rsp_hit;
   logic [VALUE_W-1:0]  rsp_value_out;
   logic [WAY_BITS-1:0] rsp_way_used;
   logic                rsp_evicted;
   logic [COUNT_W-1:0]  rsp_hit_count;
   logic [COUNT_W-1:0]  rsp_miss_count;
   logic [COUNT_W-1:0]  rsp_eviction_count;

   int                     mismatch_count;
   int                     pending_count;
   int                     burst_left   = 0;
   int                     quiet_cycles = 0;
   bit                     hold_request = 1'b0;
   logic [TOP_KEY_BITS-1:0] top_pool  [TOP_POOL];
   logic [SET_KEY_BITS-1:0] base_pool [BASE_POOL];

   set_assoc_cache_tree_plru_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_key            (req_key),
      .req_value_in       (req_value_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_value_out      (rsp_value_out),
      .rsp_way_used       (rsp_way_used),
      .rsp_evicted        (rsp_evicted),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_eviction_count (rsp_eviction_count)
   );

   set_assoc_cache_tree_plru_unit_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_key            (req_key),
      .req_value_in       (req_value_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_value_out      (rsp_value_out),
      .rsp_way_used       (rsp_way_used),
      .rsp_evicted        (rsp_evicted),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_eviction_count (rsp_eviction_count),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Offer one item. Between bursts of random length insert a random gap;
   // roughly one burst in four follows the previous one with no gap at all.
   task automatic push_item(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid    = 1'b1;
      req_kind     = kind;
      req_key      = key;
      req_value_in = value;
      // Hold the item until the block takes it.
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Draw a key from a small pool crowded into a few sets, so hits, fills and
   // evictions all come up often.
   function automatic logic [KEY_W-1:0] pool_key();
      return {top_pool[$urandom_range(0, TOP_POOL - 1)],
              base_pool[$urandom_range(0, BASE_POOL - 1)]};
   endfunction

   // Receiver: switch between stall patterns in stretches of random length,
   // and on request hold off for a long stretch so the block backs up.
   initial begin : receiver
      ready_mode_type mode;
      int             stretch_left;
      int             phase;
      mode         = READY_ALWAYS;
      stretch_left = 0;
      phase        = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (stretch_left == 0) begin
               mode         = ready_mode_type'($urandom_range(0, 3));
               stretch_left = $urandom_range(16, 64);
            end
            stretch_left--;
            phase++;
            case (mode)
               READY_ALWAYS: begin
                  rsp_ready = 1'b1;
               end
               READY_COIN: begin
                  rsp_ready = 1'($urandom_range(0, 1));
               end
               READY_SPARSE: begin
                  rsp_ready = ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_ready = (phase % 5) < 3;
               end
            endcase
         end
      end
   end

   // Watchdog: end the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [KEY_W-1:0] same_set [5];
      logic [KEY_W-1:0] key;
      logic [1:0]       kind;
      int               i;
      int               pick;

      for (i = 0; i < TOP_POOL; i++) begin
         top_pool[i] = TOP_KEY_BITS'({$urandom, $urandom});
      end
      for (i = 0; i < BASE_POOL; i++) begin
         base_pool[i] = SET_KEY_BITS'({$urandom, $urandom});
      end
      // Five keys that land in one set: the fifth insert must evict.
      for (i = 0; i < 5; i++) begin
         same_set[i] = {TOP_KEY_BITS'(i), base_pool[0]};
      end

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of key and payload, fill and evict one set,
      // updates of a present key, the unused kind and a clear.
      push_item(KIND_LOOKUP, '0, '1);
      push_item(KIND_INSERT, '0, '1);
      push_item(KIND_LOOKUP, '0, '0);
      push_item(KIND_INSERT, '1, '0);
      push_item(KIND_LOOKUP, '1, '1);
      for (i = 0; i < 5; i++) begin
         push_item(KIND_INSERT, same_set[i], $urandom);
      end
      for (i = 0; i < 5; i++) begin
         push_item(KIND_LOOKUP, same_set[i], $urandom);
      end
      push_item(KIND_INSERT, same_set[1], $urandom);
      push_item(KIND_INSERT, same_set[4], $urandom);
      push_item(KIND_NOP, '1, '1);
      push_item(KIND_CLEAR, same_set[2], $urandom);
      push_item(KIND_LOOKUP, same_set[2], $urandom);
      push_item(KIND_NOP, '0, '0);
      push_item(KIND_INSERT, same_set[2], $urandom);
      push_item(KIND_LOOKUP, same_set[2], $urandom);

      // Random: mostly pooled keys, some fully random noise keys.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == HOLD_AT) begin
            // Let the receiver back off while items keep coming.
            hold_request = 1'b1;
         end
         if (i == PAUSE_AT) begin
            // Drop valid, then pause until the block has handed back every result.
            @(negedge clock);
            req_valid = 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            kind = KIND_CLEAR;
         end else if (pick < 5) begin
            kind = KIND_NOP;
         end else if (pick < 50) begin
            kind = KIND_INSERT;
         end else begin
            kind = KIND_LOOKUP;
         end
         key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pool_key();
         push_item(kind, key, $urandom);
      end

      @(negedge clock);
      req_valid = 1'b0;
      // Drain the results, then give the block time to show any stray one.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[set_assoc_cache_tree_plru_unit.f]
+incdir+src
src/sacp_pkg.sv
src/sacp_ram.sv
src/set_assoc_cache_tree_plru_unit.sv
verif/set_assoc_cache_tree_plru_unit_checker.sv
verif/set_assoc_cache_tree_plru_unit_test.sv
